/* rtl/speck_pkg.sv */
// speck 128/128 shared types, codes and round functions
package speck_pkg;

	localparam int WORD_W = 64;

	// request codes carried with each word
	localparam logic REQ_ENCRYPT = 1'b0;
	localparam logic REQ_DECRYPT = 1'b1;

	// configuration register indexes
	localparam logic [0:0] REG_KEY_LOW  = 1'b0;
	localparam logic [0:0] REG_KEY_HIGH = 1'b1;

	typedef logic [WORD_W-1:0] word_t;

	// the two halves of a block or of the key schedule state
	typedef struct packed {
		word_t x;
		word_t y;
	} pair_t;

	// payload held by one pipeline stage
	typedef struct packed {
		logic  dec;
		word_t x;
		word_t y;
	} stage_t;

	// forward round: x = (ror8(x) + y) ^ k, y = rol3(y) ^ x
	function automatic pair_t fwd_round(input word_t x, input word_t y, input word_t k);
		pair_t r;
		word_t a;
		a   = ({x[7:0], x[63:8]} + y) ^ k;
		r.x = a;
		r.y = {y[60:0], y[63:61]} ^ a;
		return r;
	endfunction

	// inverse round: y = ror3(x ^ y), x = rol8((x ^ k) - y)
	function automatic pair_t inv_round(input word_t x, input word_t y, input word_t k);
		pair_t r;
		word_t b;
		word_t a;
		b   = x ^ y;
		b   = {b[2:0], b[63:3]};
		a   = (x ^ k) - b;
		r.x = {a[55:0], a[63:56]};
		r.y = b;
		return r;
	endfunction

endpackage

/* rtl/speck128_block_cipher.sv */
// speck 128/128 block cipher, one round per pipeline stage
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, req_type, text_*       | into block
//  out     | out_valid, out_stall, result_*             | out of block
//  cfg     | cfg_we, cfg_index, cfg_data                | into block
//
// one word accepted per cycle while in_stall is low; each accepted word passes
// through one register stage per round, all stages advance together.
// after reset and after every key write the round keys are rebuilt by a
// key schedule unit, one round per cycle, with in_stall held.
// out_stall freezes the whole pipeline while the last stage holds a word.
// arst_n clears all valid bits and the key registers to zero.
module speck128_block_cipher #(
	parameter int ROUNDS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// key configuration
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_index,
	input  speck_pkg::word_t     cfg_data,
	// input words
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 req_type,
	input  speck_pkg::word_t     text_low,
	input  speck_pkg::word_t     text_high,
	// result words
	output logic                 out_valid,
	input  logic                 out_stall,
	output speck_pkg::word_t     result_low,
	output speck_pkg::word_t     result_high
);
	import speck_pkg::*;

	localparam int CW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
	localparam logic [CW-1:0] CNT_LAST = CW'(ROUNDS - 1);

	// key registers
	word_t key_low_q;
	word_t key_high_q;

	// key schedule unit
	logic          kx_busy_q;
	logic [CW-1:0] kx_cnt_q;
	word_t         kx_a_q;
	word_t         kx_b_q;
	pair_t         kx_nxt;
	word_t         rk_q [ROUNDS];

	// pipeline
	logic          adv;
	logic          vld_s  [ROUNDS];
	stage_t        word_s [ROUNDS];

	// key register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				REG_KEY_HIGH: key_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// one schedule round, round index as key
	always_comb begin
		kx_nxt = fwd_round(kx_a_q, kx_b_q, WORD_W'(kx_cnt_q - CW'(1)));
	end

	// key schedule control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kx_busy_q <= 1'b1;
			kx_cnt_q  <= '0;
		end else if (cfg_we) begin
			kx_busy_q <= 1'b1;
			kx_cnt_q  <= '0;
		end else if (kx_busy_q) begin
			if (kx_cnt_q == CNT_LAST) begin
				kx_busy_q <= 1'b0;
			end else begin
				kx_cnt_q <= kx_cnt_q + CW'(1);
			end
		end
	end

	// key schedule datapath and round key store
	always_ff @(posedge clk) begin
		if (kx_busy_q && !cfg_we) begin
			if (kx_cnt_q == '0) begin
				kx_a_q   <= key_high_q;
				kx_b_q   <= key_low_q;
				rk_q[0]  <= key_low_q;
			end else begin
				kx_a_q         <= kx_nxt.x;
				kx_b_q         <= kx_nxt.y;
				rk_q[kx_cnt_q] <= kx_nxt.y;
			end
		end
	end

	// pipeline moves unless a finished word is held at the output
	assign adv      = !(vld_s[ROUNDS-1] && out_stall);
	assign in_stall = kx_busy_q || !adv;

	// round stages
	for (genvar j = 0; j < ROUNDS; j++) begin : g_stage
		stage_t src;
		logic   src_vld;
		pair_t  enc;
		pair_t  dcr;
		stage_t nxt;

		if (j == 0) begin : g_first
			assign src_vld = in_valid && !kx_busy_q;
			assign src     = '{dec: req_type, x: text_high, y: text_low};
		end else begin : g_next
			assign src_vld = vld_s[j-1];
			assign src     = word_s[j-1];
		end

		// forward round uses key j, inverse round uses key ROUNDS-1-j
		always_comb begin
			enc     = fwd_round(src.x, src.y, rk_q[j]);
			dcr     = inv_round(src.x, src.y, rk_q[ROUNDS-1-j]);
			nxt.dec = src.dec;
			if (src.dec == REQ_DECRYPT) begin
				nxt.x = dcr.x;
				nxt.y = dcr.y;
			end else begin
				nxt.x = enc.x;
				nxt.y = enc.y;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (adv) begin
				vld_s[j] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				word_s[j] <= nxt;
			end
		end
	end

	// result word
	assign out_valid   = vld_s[ROUNDS-1];
	assign result_low  = word_s[ROUNDS-1].y;
	assign result_high = word_s[ROUNDS-1].x;

	// no word enters while round keys are being rebuilt
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !kx_busy_q)
		else $error("word accepted during key schedule");

	// a key write always restarts the schedule
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (kx_busy_q && kx_cnt_q == '0))
		else $error("key write did not restart schedule");

	// an accepted word lands in the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_s[0])
		else $error("accepted word lost at first stage");

	// a held result keeps its payload while stalled
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[ROUNDS-1] && out_stall) |=> (vld_s[ROUNDS-1] && $stable(word_s[ROUNDS-1])))
		else $error("held result changed under stall");

endmodule
